@@ hw/rtl/dslml_pkg.sv @@
package dslml_pkg;

    localparam int unsigned AXIS_W   = 16;
    localparam int unsigned MAG_W    = 17;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP_ROT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP_MAG = 2'd3;

    localparam logic [AXIS_W-1:0] RST_MAX_STEP_AXIS = 16'd65535;
    localparam logic [MAG_W-1:0]  RST_MAX_STEP_MAG  = 17'd92682;

    typedef struct packed {
        logic signed [AXIS_W-1:0] cmd_x;
        logic signed [AXIS_W-1:0] cmd_y;
        logic signed [AXIS_W-1:0] cmd_rot;
    } t_cmd;

    typedef struct packed {
        logic signed [AXIS_W-1:0] out_x;
        logic signed [AXIS_W-1:0] out_y;
        logic signed [AXIS_W-1:0] out_rot;
    } t_res;

endpackage

@@ hw/rtl/drive_slew_and_magnitude_limiter.sv @@
// Slew and magnitude limiter for drive commands (x, y, rotation, signed Q1.15).
// Each axis moves from its last limited value by at most its step register; the
// xy magnitude floor(sqrt(x*x + y*y)) is limited against the last magnitude the
// same way, and x and y are scaled by limited over raw magnitude with truncation
// and 16-bit saturation. One 17x17 multiplier and one 32-bit subtract/compare
// are shared under a sequencer: two squares, 16 square-root steps, then for each
// of x and y one multiply and 16 restoring-divide steps (the multiplies and
// divides are skipped when x and y limit to zero). A new command is accepted
// only after the last result is registered. The result sits in an output
// register, so it can wait for the consumer while the next command is accepted.
// Register writes are taken in any cycle.
module drive_slew_and_magnitude_limiter
    import dslml_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_ready,
    input  t_cmd                 i_cmd,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output t_res                 o_res
);

    typedef enum logic [3:0] {
        S_IDLE, S_SQX, S_SQY, S_SQRT, S_MAG, S_MULX, S_DIVX, S_MULY, S_DIVY, S_DONE
    } t_state;

    t_state              r_state;
    logic [3:0]          r_cnt;
    logic [AXIS_W-1:0]   r_max_step_x;
    logic [AXIS_W-1:0]   r_max_step_y;
    logic [AXIS_W-1:0]   r_max_step_rot;
    logic [MAG_W-1:0]    r_max_step_mag;
    logic [AXIS_W-1:0]   r_last_x;
    logic [AXIS_W-1:0]   r_last_y;
    logic [AXIS_W-1:0]   r_last_rot;
    logic [MAG_W-1:0]    r_last_mag;
    logic [AXIS_W-1:0]   r_raw;
    logic [31:0]         r_acc;
    logic [31:0]         r_root;
    logic [31:0]         r_bit;
    logic [31:0]         r_div;
    logic [AXIS_W-1:0]   r_quo;
    logic [AXIS_W-1:0]   r_out_x;
    logic                r_res_valid;
    t_res                r_res;

    logic [MAG_W-1:0]    mul_a;
    logic [MAG_W-1:0]    mul_b;
    logic [2*MAG_W-1:0]  mul_p;
    logic [31:0]         sub_a;
    logic [31:0]         sub_b;
    logic [32:0]         sub_d;
    logic                sub_ge;
    logic [AXIS_W-1:0]   abs_x;
    logic [AXIS_W-1:0]   abs_y;
    logic [AXIS_W-1:0]   quo_next;
    logic [MAG_W-1:0]    lim_next;

    function automatic logic [AXIS_W-1:0] slew_axis(
        input logic [AXIS_W-1:0] prev,
        input logic [AXIS_W-1:0] tgt,
        input logic [AXIS_W-1:0] step
    );
        logic signed [17:0] d;
        logic signed [17:0] s;
        logic signed [17:0] c;
        logic [17:0]        sum;
        d = $signed({{2{tgt[15]}}, tgt}) - $signed({{2{prev[15]}}, prev});
        s = $signed({2'b00, step});
        if (d > s) begin
            c = s;
        end else if (d < -s) begin
            c = -s;
        end else begin
            c = d;
        end
        sum = $unsigned($signed({{2{prev[15]}}, prev}) + c);
        return sum[AXIS_W-1:0];
    endfunction

    function automatic logic [MAG_W-1:0] slew_mag(
        input logic [MAG_W-1:0]  prev,
        input logic [AXIS_W-1:0] tgt,
        input logic [MAG_W-1:0]  step
    );
        logic signed [18:0] d;
        logic signed [18:0] s;
        logic signed [18:0] c;
        logic [18:0]        sum;
        d = $signed({3'b000, tgt}) - $signed({2'b00, prev});
        s = $signed({2'b00, step});
        if (d > s) begin
            c = s;
        end else if (d < -s) begin
            c = -s;
        end else begin
            c = d;
        end
        sum = $unsigned($signed({2'b00, prev}) + c);
        return sum[MAG_W-1:0];
    endfunction

    function automatic logic [AXIS_W-1:0] sat_signed(
        input logic              neg,
        input logic [AXIS_W-1:0] mag
    );
        logic [AXIS_W-1:0] r;
        if (neg) begin
            r = (mag > 16'd32768) ? 16'h8000 : (16'd0 - mag);
        end else begin
            r = (mag > 16'd32767) ? 16'h7FFF : mag;
        end
        return r;
    endfunction

    assign abs_x = r_last_x[15] ? (16'd0 - r_last_x) : r_last_x;
    assign abs_y = r_last_y[15] ? (16'd0 - r_last_y) : r_last_y;

    always_comb begin
        case (r_state)
            S_SQX: begin
                mul_a = {1'b0, abs_x};
                mul_b = {1'b0, abs_x};
            end
            S_SQY: begin
                mul_a = {1'b0, abs_y};
                mul_b = {1'b0, abs_y};
            end
            S_MULX: begin
                mul_a = {1'b0, abs_x};
                mul_b = r_last_mag;
            end
            S_MULY: begin
                mul_a = {1'b0, abs_y};
                mul_b = r_last_mag;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        sub_a = r_acc;
        case (r_state)
            S_SQRT:  sub_b = r_root | r_bit;
            default: sub_b = r_div;
        endcase
    end

    assign sub_d    = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge   = ~sub_d[32];
    assign quo_next = {r_quo[AXIS_W-2:0], sub_ge};
    assign lim_next = slew_mag(r_last_mag, r_root[AXIS_W-1:0], r_max_step_mag);

    assign o_cfg_ready = 1'b1;
    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_cnt          <= '0;
            r_res_valid    <= 1'b0;
            r_max_step_x   <= RST_MAX_STEP_AXIS;
            r_max_step_y   <= RST_MAX_STEP_AXIS;
            r_max_step_rot <= RST_MAX_STEP_AXIS;
            r_max_step_mag <= RST_MAX_STEP_MAG;
            r_last_x       <= '0;
            r_last_y       <= '0;
            r_last_rot     <= '0;
            r_last_mag     <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MAX_STEP_X:   r_max_step_x   <= i_cfg_data[AXIS_W-1:0];
                    CFG_MAX_STEP_Y:   r_max_step_y   <= i_cfg_data[AXIS_W-1:0];
                    CFG_MAX_STEP_ROT: r_max_step_rot <= i_cfg_data[AXIS_W-1:0];
                    CFG_MAX_STEP_MAG: r_max_step_mag <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_res_valid && i_res_ready && (r_state != S_DONE)) begin
                r_res_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_last_x   <= slew_axis(r_last_x, i_cmd.cmd_x, r_max_step_x);
                        r_last_y   <= slew_axis(r_last_y, i_cmd.cmd_y, r_max_step_y);
                        r_last_rot <= slew_axis(r_last_rot, i_cmd.cmd_rot, r_max_step_rot);
                        r_state    <= S_SQX;
                    end
                end
                S_SQX: begin
                    r_acc   <= mul_p[31:0];
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_acc   <= r_acc + mul_p[31:0];
                    r_root  <= '0;
                    r_bit   <= 32'h4000_0000;
                    r_cnt   <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (sub_ge) begin
                        r_acc  <= sub_d[31:0];
                        r_root <= (r_root >> 1) | r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_state <= S_MAG;
                    end
                end
                S_MAG: begin
                    r_raw      <= r_root[AXIS_W-1:0];
                    r_last_mag <= lim_next;
                    if (r_root[AXIS_W-1:0] == '0) begin
                        r_out_x <= r_last_x;
                        r_quo   <= r_last_y;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_MULX;
                    end
                end
                S_MULX, S_MULY: begin
                    r_acc   <= mul_p[31:0];
                    r_div   <= {1'b0, r_raw, 15'd0};
                    r_quo   <= '0;
                    r_cnt   <= '0;
                    r_state <= (r_state == S_MULX) ? S_DIVX : S_DIVY;
                end
                S_DIVX, S_DIVY: begin
                    if (sub_ge) begin
                        r_acc <= sub_d[31:0];
                    end
                    r_div <= r_div >> 1;
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        if (r_state == S_DIVX) begin
                            r_out_x <= sat_signed(r_last_x[15], quo_next);
                            r_quo   <= quo_next;
                            r_state <= S_MULY;
                        end else begin
                            r_quo   <= sat_signed(r_last_y[15], quo_next);
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_quo <= quo_next;
                    end
                end
                S_DONE: begin
                    if (!r_res_valid || i_res_ready) begin
                        r_res.out_x   <= r_out_x;
                        r_res.out_y   <= r_quo;
                        r_res.out_rot <= r_last_rot;
                        r_res_valid   <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
